@@ design/esfa_pkg.sv @@
// Shared constants, beat types and table functions for the Ewald structure factor accumulator.
// Used by the channel interfaces, the top level and the checker.
package esfa_pkg;

    localparam int K_MAX      = 4;
    localparam int COORD_BITS = 16;
    localparam int PHASE_BITS = 10;
    localparam int ACC_BITS   = 48;

    localparam int GRID      = 2 * K_MAX + 1;
    localparam int SLOTS     = GRID * GRID * GRID;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int QUARTER   = 1 << (PHASE_BITS - 2);
    localparam int PHASE_SH  = COORD_BITS - PHASE_BITS;
    localparam int K_W       = $clog2(K_MAX + 1) + 1;
    localparam int SIN_W     = 16;
    localparam int PROD_W    = 16 + SIN_W + 1;

    localparam int LIM_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;
    localparam int Q_W       = 16;
    localparam int FRAC_W    = 16;
    localparam int IDX_W     = 10;
    localparam int WAVE_W    = 4;
    localparam int RHO_W     = 48;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Rounded-up reciprocals of the series divisors (2n)(2n+1). The quotient is exact for
    // every dividend below 2^33, which bounds each series term.
    localparam int TAYLOR_SH = 42;
    localparam longint unsigned TAYLOR_RECIP [10] = '{
        ((64'd1 << TAYLOR_SH) + 64'd5) / 64'd6,
        ((64'd1 << TAYLOR_SH) + 64'd19) / 64'd20,
        ((64'd1 << TAYLOR_SH) + 64'd41) / 64'd42,
        ((64'd1 << TAYLOR_SH) + 64'd71) / 64'd72,
        ((64'd1 << TAYLOR_SH) + 64'd109) / 64'd110,
        ((64'd1 << TAYLOR_SH) + 64'd155) / 64'd156,
        ((64'd1 << TAYLOR_SH) + 64'd209) / 64'd210,
        ((64'd1 << TAYLOR_SH) + 64'd271) / 64'd272,
        ((64'd1 << TAYLOR_SH) + 64'd341) / 64'd342,
        ((64'd1 << TAYLOR_SH) + 64'd419) / 64'd420
    };

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Z = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [Q_W-1:0]    charge;
        logic [FRAC_W-1:0]        frac_x;
        logic [FRAC_W-1:0]        frac_y;
        logic [FRAC_W-1:0]        frac_z;
        logic [IDX_W-1:0]         entry_index;
    } t_in_beat;

    typedef struct packed {
        logic                     entry_valid;
        logic signed [WAVE_W-1:0] wave_x;
        logic signed [WAVE_W-1:0] wave_y;
        logic signed [WAVE_W-1:0] wave_z;
        logic signed [RHO_W-1:0]  rho_real;
        logic signed [RHO_W-1:0]  rho_imag;
    } t_out_beat;

    typedef logic [SIN_W-1:0] t_sine_tab [QUARTER+1];

    function automatic t_sine_tab build_sine();
        t_sine_tab         tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            s;
        logic [127:0]      prod;
        for (int i = 0; i <= QUARTER; i++) begin
            x    = (longint'(i) * HALF_PI_Q30) >> (PHASE_BITS - 2);
            x2   = (x * x) >> 30;
            term = x;
            s    = longint'(x);
            for (int n = 1; n <= 10; n++) begin
                term = (term * x2) >> 30;
                prod = 128'(term) * 128'(TAYLOR_RECIP[n-1]);
                term = 64'(prod >> TAYLOR_SH);
                if (n[0]) begin
                    s = s - longint'(term);
                end else begin
                    s = s + longint'(term);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            tab[i] = SIN_W'((s + 16384) >>> 15);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

    function automatic logic signed [SIN_W:0] sine_of(input logic [PHASE_BITS-1:0] p);
        logic [1:0]            quad;
        logic [PHASE_BITS-3:0] r;
        logic [SIN_W:0]        v;
        quad = p[PHASE_BITS-1:PHASE_BITS-2];
        r    = p[PHASE_BITS-3:0];
        if (quad[0]) begin
            v = {1'b0, SINE_TAB[QUARTER - int'(r)]};
        end else begin
            v = {1'b0, SINE_TAB[int'(r)]};
        end
        return quad[1] ? -signed'(v) : signed'(v);
    endfunction

    function automatic logic [PHASE_BITS-1:0] phase_idx(input logic [COORD_BITS-1:0] turn);
        logic [COORD_BITS:0] rnd;
        rnd = {1'b0, turn} + (COORD_BITS + 1)'(1 << (PHASE_SH - 1));
        return rnd[PHASE_SH +: PHASE_BITS];
    endfunction

endpackage

@@ design/esfa_in_if.sv @@
// Input channel carrying particle, clear and read beats.
// Depends on esfa_pkg for the beat type.
interface esfa_in_if import esfa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/esfa_out_if.sv @@
// Output channel carrying entry read beats.
// Depends on esfa_pkg for the beat type.
interface esfa_out_if import esfa_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/ewald_structure_factor_accumulator_top.sv @@
// Ewald structure factor accumulator: one memory of complex sums, updated by read-modify-write.
// Depends on esfa_pkg, esfa_in_if and esfa_out_if.
// An add beat walks up to 728 nonzero wave vectors, one memory update per cycle apart from
// the origin; it updates nothing when every limit is zero.
// A read beat walks the enumeration to the entry and reads it from memory; an index out of
// range gives an all-zero invalid result beat without the walk.
// A clear beat only resets the fill count, which marks entries written since the last clear.
// Synchronous active-low reset restores limits of 4 and an empty accumulator.
module ewald_structure_factor_accumulator_top import esfa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIM_W-1:0]     i_cfg_data,
    esfa_in_if.sink              i_in,
    esfa_out_if.source           o_out
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ADD    = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_SEEK   = 6'b001000,
        ST_RDWAIT = 6'b010000,
        ST_OUT    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [LIM_W-1:0] r_lim_x, r_lim_y, r_lim_z;
    logic signed [Q_W-1:0] r_q, n_q;
    logic [FRAC_W-1:0] r_fx, r_fy, r_fz, n_fx, n_fy, n_fz;
    logic [SLOT_W-1:0] r_idx, n_idx, r_slot, n_slot, r_hw, n_hw;
    logic signed [K_W-1:0] r_kx, r_ky, r_kz, n_kx, n_ky, n_kz;
    t_out_beat r_out, n_out;
    logic r_out_vld, n_out_vld;

    logic r_s1_vld, n_s1_vld, r_s2_vld, r_s3_vld;
    logic [SLOT_W-1:0] r_s1_slot, r_s2_slot, r_s3_slot;
    logic [PHASE_BITS-1:0] r_s1_p;
    logic signed [SIN_W:0] r_s2_sin, r_s2_cos;
    logic [ACC_BITS-1:0] r_s2_re, r_s2_im, r_s3_re, r_s3_im;
    logic signed [PROD_W-1:0] r_s3_pre, r_s3_pim;

    logic [2*ACC_BITS-1:0] r_mem [SLOTS];
    logic [2*ACC_BITS-1:0] r_mem_q;

    logic [LIM_W-1:0] w_lx, w_ly, w_lz;
    logic signed [K_W-1:0] w_lxs, w_lys, w_lzs;
    logic [SLOT_W-1:0] w_cnt;
    logic w_origin, w_end, w_acc;
    logic [COORD_BITS-1:0] w_turn;
    logic [PHASE_BITS-1:0] w_p;
    logic [ACC_BITS-1:0] w_sum_re, w_sum_im;

    assign w_lx  = (r_lim_x > LIM_W'(K_MAX)) ? LIM_W'(K_MAX) : r_lim_x;
    assign w_ly  = (r_lim_y > LIM_W'(K_MAX)) ? LIM_W'(K_MAX) : r_lim_y;
    assign w_lz  = (r_lim_z > LIM_W'(K_MAX)) ? LIM_W'(K_MAX) : r_lim_z;
    assign w_lxs = signed'(K_W'(w_lx));
    assign w_lys = signed'(K_W'(w_ly));
    assign w_lzs = signed'(K_W'(w_lz));
    assign w_cnt = SLOT_W'((2 * int'(w_lx) + 1) * (2 * int'(w_ly) + 1)
                   * (2 * int'(w_lz) + 1) - 1);

    assign w_origin = (r_kx == '0) && (r_ky == '0) && (r_kz == '0);
    assign w_end    = (r_kx == w_lxs) && (r_ky == w_lys) && (r_kz == w_lzs);
    assign w_acc    = i_in.valid && i_in.ready;

    assign w_turn = COORD_BITS'(r_fx * COORD_BITS'(r_kx))
                  + COORD_BITS'(r_fy * COORD_BITS'(r_ky))
                  + COORD_BITS'(r_fz * COORD_BITS'(r_kz));
    assign w_p    = phase_idx(w_turn);

    assign w_sum_re = r_s3_re + ACC_BITS'(r_s3_pre);
    assign w_sum_im = r_s3_im + ACC_BITS'(r_s3_pim);

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    always_comb begin
        n_state   = r_state;
        n_q       = r_q;
        n_fx      = r_fx;
        n_fy      = r_fy;
        n_fz      = r_fz;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_hw      = r_hw;
        n_kx      = r_kx;
        n_ky      = r_ky;
        n_kz      = r_kz;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        n_s1_vld  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_kx   = -w_lxs;
                    n_ky   = -w_lys;
                    n_kz   = -w_lzs;
                    n_slot = '0;
                    case (i_in.data.mode)
                        MODE_CLEAR: begin
                            n_hw = '0;
                        end
                        MODE_ADD: begin
                            n_q     = i_in.data.charge;
                            n_fx    = i_in.data.frac_x;
                            n_fy    = i_in.data.frac_y;
                            n_fz    = i_in.data.frac_z;
                            n_state = ST_ADD;
                        end
                        MODE_READ: begin
                            n_idx = SLOT_W'(i_in.data.entry_index);
                            if (i_in.data.entry_index >= IDX_W'(w_cnt)) begin
                                n_out     = '0;
                                n_out_vld = 1'b1;
                                n_state   = ST_OUT;
                            end else begin
                                n_state = ST_SEEK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD, ST_SEEK: begin
                if ((r_state == ST_SEEK) && !w_origin && (r_slot == r_idx)) begin
                    n_state = ST_RDWAIT;
                end else begin
                    if (!w_origin) begin
                        n_slot = r_slot + 1'b1;
                    end
                    n_s1_vld = (r_state == ST_ADD) && !w_origin;
                    if ((r_state == ST_ADD) && w_end) begin
                        n_state = ST_DRAIN;
                    end else if (r_kz == w_lzs) begin
                        n_kz = -w_lzs;
                        if (r_ky == w_lys) begin
                            n_ky = -w_lys;
                            n_kx = r_kx + 1'b1;
                        end else begin
                            n_ky = r_ky + 1'b1;
                        end
                    end else begin
                        n_kz = r_kz + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld && !r_s3_vld) begin
                    if (w_cnt > r_hw) begin
                        n_hw = w_cnt;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_RDWAIT: begin
                n_out.entry_valid = 1'b1;
                n_out.wave_x      = WAVE_W'(r_kx);
                n_out.wave_y      = WAVE_W'(r_ky);
                n_out.wave_z      = WAVE_W'(r_kz);
                if (r_slot >= r_hw) begin
                    n_out.rho_real = '0;
                    n_out.rho_imag = '0;
                end else begin
                    n_out.rho_real = RHO_W'(signed'(r_mem_q[2*ACC_BITS-1:ACC_BITS]));
                    n_out.rho_imag = RHO_W'(signed'(r_mem_q[ACC_BITS-1:0]));
                end
                n_out_vld = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_out_vld = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_lim_x   <= LIM_W'(4);
            r_lim_y   <= LIM_W'(4);
            r_lim_z   <= LIM_W'(4);
            r_hw      <= '0;
            r_out_vld <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hw      <= n_hw;
            r_out_vld <= n_out_vld;
            r_s1_vld  <= n_s1_vld;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIMIT_X: r_lim_x <= i_cfg_data;
                    CFG_LIMIT_Y: r_lim_y <= i_cfg_data;
                    CFG_LIMIT_Z: r_lim_z <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q       <= n_q;
        r_fx      <= n_fx;
        r_fy      <= n_fy;
        r_fz      <= n_fz;
        r_idx     <= n_idx;
        r_slot    <= n_slot;
        r_kx      <= n_kx;
        r_ky      <= n_ky;
        r_kz      <= n_kz;
        r_out     <= n_out;
        r_s1_slot <= r_slot;
        r_s1_p    <= w_p;
        r_s2_slot <= r_s1_slot;
        r_s2_sin  <= sine_of(r_s1_p);
        r_s2_cos  <= sine_of(r_s1_p + PHASE_BITS'(QUARTER));
        if (r_s1_slot >= r_hw) begin
            r_s2_re <= '0;
            r_s2_im <= '0;
        end else begin
            r_s2_re <= r_mem_q[2*ACC_BITS-1:ACC_BITS];
            r_s2_im <= r_mem_q[ACC_BITS-1:0];
        end
        r_s3_slot <= r_s2_slot;
        r_s3_re   <= r_s2_re;
        r_s3_im   <= r_s2_im;
        r_s3_pre  <= PROD_W'(r_q) * PROD_W'(r_s2_cos);
        r_s3_pim  <= PROD_W'(r_q) * PROD_W'(r_s2_sin);
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_vld) begin
            r_mem[r_s3_slot] <= {w_sum_re, w_sum_im};
        end
        r_mem_q <= r_mem[r_slot];
    end

endmodule

@@ design/esfa_checker.sv @@
// Port-level assertions for the Ewald structure factor accumulator, bound to its top level.
// Depends on esfa_pkg for the result beat type.
module esfa_checker import esfa_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_beat i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("Result beat changed while stalled.");

    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("Input ready while a result beat is pending.");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.entry_valid |->
            i_out_data.rho_real == '0 && i_out_data.rho_imag == '0 &&
            i_out_data.wave_x == '0 && i_out_data.wave_y == '0 && i_out_data.wave_z == '0)
        else $error("Invalid entry carries nonzero fields.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result beat valid right after reset.");

    a_wave_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.entry_valid |->
            i_out_data.wave_x >= -WAVE_W'(K_MAX) && i_out_data.wave_x <= WAVE_W'(K_MAX))
        else $error("Wave index out of range.");

endmodule

bind ewald_structure_factor_accumulator_top esfa_checker u_esfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
